>>> rtl/gtc_pkg.sv
// Shared types and constants for the transitive closure block.
// Used by gtc_cell and graph_transitive_closure; depends on nothing.
`default_nettype none
package gtc_pkg;

  localparam int NODE_W = 6;   // node index width
  localparam int ROW_W  = 64;  // reachability row width
  localparam int CNT_W  = 7;   // node count width

  // input kinds
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  // cell operations
  localparam logic [2:0] OP_HOLD  = 3'd0;
  localparam logic [2:0] OP_EDGE  = 3'd1;
  localparam logic [2:0] OP_TRIM  = 3'd2;
  localparam logic [2:0] OP_PIVOT = 3'd3;
  localparam logic [2:0] OP_SHIFT = 3'd4;

  typedef struct packed {
    logic [2:0]        op;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic [NODE_W-1:0] pivot;
    logic [CNT_W-1:0]  n;
  } gtc_ctl_t;

endpackage
`default_nettype wire

>>> rtl/gtc_cell.sv
// One cell of the row ring: holds a single reachability row.
// Depends on gtc_pkg for the control struct and operation codes.
`default_nettype none
module gtc_cell #(
  parameter int CELL_IDX = 0
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire gtc_pkg::gtc_ctl_t        ctl,
  input  wire logic [gtc_pkg::ROW_W-1:0] nbr_row,
  input  wire logic [gtc_pkg::ROW_W-1:0] pivot_row,
  output logic      [gtc_pkg::ROW_W-1:0] row_r
);
  import gtc_pkg::*;

  localparam logic [NODE_W-1:0] IDX_V = NODE_W'(CELL_IDX);
  localparam logic [CNT_W-1:0]  IDX_N = CNT_W'(CELL_IDX);

  logic [ROW_W-1:0] row_nxt;
  logic [ROW_W-1:0] keep_mask;

  // bits at or beyond the node count are dropped at run start
  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      keep_mask[j] = (CNT_W'(j) < ctl.n);
    end
  end

  always_comb begin
    row_nxt = row_r;
    case (ctl.op)
      OP_EDGE: begin
        if (ctl.src == IDX_V) begin
          row_nxt = row_r | (ROW_W'(1) << ctl.dst);
        end
      end
      OP_TRIM:  row_nxt = (IDX_N < ctl.n) ? (row_r & keep_mask) : '0;
      // update the incoming row with the pivot row, then it moves one cell on
      OP_PIVOT: row_nxt = nbr_row | (nbr_row[ctl.pivot] ? pivot_row : '0);
      OP_SHIFT: row_nxt = nbr_row;
      default:  row_nxt = row_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/graph_transitive_closure.sv
// Transitive closure over a ring of MAX_NODES row cells.
// Edge beats: one per cycle while idle, no result. Run beat: a pivot pass over
// MAX_NODES pivots (ring steps one cell per pivot), then n rows at one per
// cycle unless the output stalls; next beat taken once the last row is loaded.
// Output stalls hold the row ring. Reset (synchronous, rst_n low) clears the
// matrix at once; node_count = 64.
`default_nettype none
module graph_transitive_closure #(
  parameter int MAX_NODES = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // configuration: node_count
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [gtc_pkg::CNT_W-1:0] cfg_data,
  // input channel
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [15:0]               in_tdata,  // src_node[5:0], dst_node[11:6], zeros
  input  wire logic                      in_tuser,  // kind
  // result channel
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic      [71:0]               out_tdata, // row_index[5:0], row_bits[69:6], zeros
  output logic                           out_tlast  // last_row
);
  import gtc_pkg::*;

  localparam int KW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CLOSE = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [KW-1:0]     cnt_r, cnt_nxt;
  logic [NODE_W-1:0] emit_r, emit_nxt;
  logic [CNT_W-1:0]  node_count_r;
  logic [CNT_W-1:0]  n_eff;

  logic              out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0] out_idx_r;
  logic [ROW_W-1:0]  out_row_r;
  logic              out_last_r;
  logic              out_load;
  logic              emit_last;

  gtc_ctl_t          ctl;
  logic [NODE_W-1:0] in_src, in_dst;
  logic [ROW_W-1:0]  cell_row [MAX_NODES];
  logic [ROW_W-1:0]  cell_nbr [MAX_NODES];

  assign in_src = in_tdata[5:0];
  assign in_dst = in_tdata[11:6];

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= CNT_W'(64);
    end else if (cfg_valid) begin
      node_count_r <= cfg_data;
    end
  end

  always_comb begin
    if (node_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (node_count_r > CNT_W'(MAX_NODES)) begin
      n_eff = CNT_W'(MAX_NODES);
    end else begin
      n_eff = node_count_r;
    end
  end

  assign emit_last = ((CNT_W'(emit_r) + CNT_W'(1)) == n_eff);
  assign out_load  = (state_r == ST_EMIT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    emit_nxt      = emit_r;
    out_valid_nxt = out_valid_r;
    ctl.op        = OP_HOLD;
    ctl.src       = in_src;
    ctl.dst       = in_dst;
    ctl.pivot     = NODE_W'(cnt_r);
    ctl.n         = n_eff;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == KIND_RUN) begin
            ctl.op    = OP_TRIM;
            cnt_nxt   = '0;
            state_nxt = ST_CLOSE;
          end else if ((CNT_W'(in_src) < n_eff) && (CNT_W'(in_dst) < n_eff)) begin
            ctl.op = OP_EDGE;
          end
        end
      end
      ST_CLOSE: begin
        ctl.op  = OP_PIVOT;
        cnt_nxt = cnt_r + KW'(1);
        if (cnt_r == KW'(MAX_NODES - 1)) begin
          emit_nxt  = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          ctl.op        = OP_SHIFT;
          out_valid_nxt = 1'b1;
          emit_nxt      = emit_r + NODE_W'(1);
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r  <= emit_r;
      out_row_r  <= cell_row[0];
      out_last_r <= emit_last;
    end
  end

  // rows move towards cell 0; the head cell holds the current pivot row
  genvar gi;
  generate
    for (gi = 0; gi < MAX_NODES; gi++) begin : g_cell
      if (gi == MAX_NODES - 1) begin : g_tail
        assign cell_nbr[gi] = (state_r == ST_CLOSE) ? cell_row[0] : '0;
      end else begin : g_body
        assign cell_nbr[gi] = cell_row[gi+1];
      end
      gtc_cell #(
        .CELL_IDX (gi)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .nbr_row   (cell_nbr[gi]),
        .pivot_row (cell_row[0]),
        .row_r     (cell_row[gi])
      );
    end
  endgenerate

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_row_r, out_idx_r};
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire
